// ===== hdl/tafv_pkg.sv =====
// ----------------------------------------------------------------------------
// Triangle angle unit package
// Shared widths, constants, the arctangent table and a helper function.
// ----------------------------------------------------------------------------
package tafv_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int ANGLE_FRAC_DEF = 8;

    // Output field widths are fixed by the interface.
    localparam int SIDE_W = 25;
    localparam int ANGLE_W = 16;
    localparam int OUT_W = ((3 * SIDE_W + 3 * ANGLE_W + 7) / 8) * 8;

    // Lengths carry eight fraction bits.
    localparam int LEN_FRAC = 8;

    // Cosine quotient: 21 bits, capped at 2^20, then rounded to Q1.16.
    localparam int DIV_STEPS = 21;
    localparam int DIV_PRE = 32 - DIV_STEPS;
    localparam logic [DIV_STEPS-1:0] QUOT_CAP = DIV_STEPS'(1 << 20);
    localparam int COS_W = 17;
    localparam logic [COS_W-1:0] COS_ONE = COS_W'(1 << 16);

    // Sine root: sqrt of a 33-bit value with one rounding bit.
    localparam int SQ2_STEPS = 18;

    // Rotation unit.
    localparam int CORDIC_STEPS = 26;
    localparam int VEC_SHIFT = 14;
    localparam int Z_FRAC = 20;
    localparam int XY_W = 34;
    localparam int Z_W = 29;
    localparam int ATAN_W = 27;
    localparam logic signed [Z_W-1:0] HALF_TURN = Z_W'(180 * (1 << Z_FRAC));

    // atan(2^-i) in degrees, units of 2^-20 degree.
    localparam logic [ATAN_W-1:0] ATAN_DEG [CORDIC_STEPS] = '{
        27'd47185920, 27'd27855475, 27'd14718068, 27'd7471121, 27'd3750058,
        27'd1876857, 27'd938658, 27'd469357, 27'd234682, 27'd117342,
        27'd58671, 27'd29335, 27'd14668, 27'd7334, 27'd3667, 27'd1833,
        27'd917, 27'd458, 27'd229, 27'd115, 27'd57, 27'd29, 27'd14, 27'd7,
        27'd4, 27'd2
    };

    // Stages inside one angle lane, input to registered angle.
    localparam int LANE_LAT = 6 + DIV_STEPS + SQ2_STEPS + CORDIC_STEPS;

    // Arithmetic right shift that rounds toward zero.
    function automatic logic signed [XY_W-1:0] shr_tz(input logic signed [XY_W-1:0] v,
                                                      input int unsigned sh);
        logic signed [XY_W-1:0] m;
        begin
            m = v[XY_W-1] ? -v : v;
            m = m >>> sh;
            return v[XY_W-1] ? -m : m;
        end
    endfunction

endpackage

// ===== hdl/triangle_angles_from_vertices_unit.sv =====
// ----------------------------------------------------------------------------
// Triangle angles from vertices
// Side lengths and interior angles of a triangle by the law of cosines.
// ----------------------------------------------------------------------------
// Throughput: one triangle per cycle while the chain is not held; every stage is a register in a chain of cells.
// The whole chain holds while an output beat waits and the sink is not ready.
// Reset clears only the valid bits of the chain; data registers are not reset.
module triangle_angles_from_vertices_unit #(
    parameter int COORD_BITS = tafv_pkg::COORD_BITS_DEF,
    parameter int ANGLE_FRAC_BITS = tafv_pkg::ANGLE_FRAC_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // ax, ay, bx, by, cx, cy from the lowest bit up
    input  logic [((6*COORD_BITS+7)/8)*8-1:0]      i_s_axis_tdata,
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    // side_bc, side_ac, side_ab, angle_at_a, angle_at_b, angle_at_c from the lowest bit up
    output logic [tafv_pkg::OUT_W-1:0]             o_m_axis_tdata,
    // degenerate
    output logic [0:0]                             o_m_axis_tuser
);
    import tafv_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int D2W = 2 * CW + 1;
    localparam int LSH = 2 * (LEN_FRAC + 1);
    localparam int SQ_ITER = (D2W + LSH + 1) / 2;
    localparam int RAD_W = 2 * SQ_ITER;
    localparam int LW = SQ_ITER;
    localparam int NUM_W = D2W + 1;
    localparam int TOT = 4 + SQ_ITER + LANE_LAT;

    logic w_en;
    logic r_vld [TOT];

    assign w_en = !r_vld[TOT-1] || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TOT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= i_s_axis_tvalid;
            for (int k = 1; k < TOT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Coordinate differences for the sides BC, AC and AB.
    logic signed [CW-1:0] w_crd [6];
    logic signed [CW:0]   w_dif [6];
    logic [CW-1:0]        w_mag [6];
    logic [CW-1:0]        r_mag [6];
    logic [2*CW-1:0]      r_sq  [6];
    logic [D2W-1:0]       r_d2  [3];

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            w_crd[k] = i_s_axis_tdata[k*CW +: CW];
        end
        w_dif[0] = (CW + 1)'(w_crd[4]) - (CW + 1)'(w_crd[2]);
        w_dif[1] = (CW + 1)'(w_crd[5]) - (CW + 1)'(w_crd[3]);
        w_dif[2] = (CW + 1)'(w_crd[4]) - (CW + 1)'(w_crd[0]);
        w_dif[3] = (CW + 1)'(w_crd[5]) - (CW + 1)'(w_crd[1]);
        w_dif[4] = (CW + 1)'(w_crd[2]) - (CW + 1)'(w_crd[0]);
        w_dif[5] = (CW + 1)'(w_crd[3]) - (CW + 1)'(w_crd[1]);
        for (int k = 0; k < 6; k++) begin
            w_mag[k] = w_dif[k][CW] ? CW'(-w_dif[k]) : CW'(w_dif[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 6; k++) begin
                r_mag[k] <= w_mag[k];
                r_sq[k]  <= (2 * CW)'(r_mag[k]) * (2 * CW)'(r_mag[k]);
            end
            for (int k = 0; k < 3; k++) begin
                r_d2[k] <= D2W'(r_sq[2*k]) + D2W'(r_sq[2*k+1]);
            end
        end
    end

    // Three length roots, one cell per digit.
    logic [RAD_W-1:0]   w_rad  [3][SQ_ITER+1];
    logic [SQ_ITER+1:0] w_rem  [3][SQ_ITER+1];
    logic [SQ_ITER-1:0] w_root [3][SQ_ITER+1];

    for (genvar g = 0; g < 3; g++) begin : g_len
        assign w_rad[g][0]  = RAD_W'(r_d2[g]) << LSH;
        assign w_rem[g][0]  = '0;
        assign w_root[g][0] = '0;
        for (genvar k = 0; k < SQ_ITER; k++) begin : g_cell
            tafv_sqrt_cell #(.ROOT_BITS(SQ_ITER)) u_cell (
                .i_clk  (i_clk),
                .i_en   (w_en),
                .i_rad  (w_rad[g][k]),
                .i_rem  (w_rem[g][k]),
                .i_root (w_root[g][k]),
                .o_rad  (w_rad[g][k+1]),
                .o_rem  (w_rem[g][k+1]),
                .o_root (w_root[g][k+1])
            );
        end
    end

    // Squared lengths wait beside the roots, then give the cosine numerators.
    logic [D2W-1:0]     r_d2_dly [SQ_ITER][3];
    logic [D2W+1:0]     w_num [3];
    logic [SQ_ITER:0]   w_lp  [3];
    logic [LW-1:0]      r_len [3];
    logic [NUM_W-1:0]   r_num_mag [3];
    logic               r_num_neg [3];
    logic               r_degen;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_num[k] = (D2W + 2)'(r_d2_dly[SQ_ITER-1][0]) + (D2W + 2)'(r_d2_dly[SQ_ITER-1][1])
                     + (D2W + 2)'(r_d2_dly[SQ_ITER-1][2])
                     - ((D2W + 2)'(r_d2_dly[SQ_ITER-1][k]) << 1);
            w_lp[k]  = {1'b0, w_root[k][SQ_ITER]} + (SQ_ITER + 1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d2_dly[0] <= r_d2;
            for (int k = 1; k < SQ_ITER; k++) begin
                r_d2_dly[k] <= r_d2_dly[k-1];
            end
            for (int k = 0; k < 3; k++) begin
                r_len[k]     <= w_lp[k][SQ_ITER:1];
                r_num_neg[k] <= w_num[k][D2W+1];
                r_num_mag[k] <= w_num[k][D2W+1] ? NUM_W'(-w_num[k]) : NUM_W'(w_num[k]);
            end
            r_degen <= (r_d2_dly[SQ_ITER-1][0] == '0) || (r_d2_dly[SQ_ITER-1][1] == '0)
                    || (r_d2_dly[SQ_ITER-1][2] == '0);
        end
    end

    // Angle lanes: at A from AC and AB, at B from BC and AB, at C from BC and AC.
    logic [ANGLE_W-1:0] w_angle [3];

    for (genvar g = 0; g < 3; g++) begin : g_ang
        tafv_angle_lane #(
            .LEN_W           (LW),
            .NUM_W           (NUM_W),
            .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
        ) u_lane (
            .i_clk     (i_clk),
            .i_en      (w_en),
            .i_num_mag (r_num_mag[g]),
            .i_num_neg (r_num_neg[g]),
            .i_len_a   (r_len[(g == 0) ? 1 : 0]),
            .i_len_b   (r_len[(g == 2) ? 1 : 2]),
            .o_angle   (w_angle[g])
        );
    end

    // Lengths and the degenerate flag wait for the angles.
    logic [LW-1:0] r_side_dly  [LANE_LAT][3];
    logic          r_degen_dly [LANE_LAT];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side_dly[0]  <= r_len;
            r_degen_dly[0] <= r_degen;
            for (int k = 1; k < LANE_LAT; k++) begin
                r_side_dly[k]  <= r_side_dly[k-1];
                r_degen_dly[k] <= r_degen_dly[k-1];
            end
        end
    end

    logic [SIDE_W-1:0]  w_side [3];
    logic [ANGLE_W-1:0] w_ang_out [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_side[k]    = SIDE_W'(r_side_dly[LANE_LAT-1][k]);
            w_ang_out[k] = r_degen_dly[LANE_LAT-1] ? '0 : w_angle[k];
        end
    end

    assign o_m_axis_tvalid = r_vld[TOT-1];
    assign o_m_axis_tuser  = r_degen_dly[LANE_LAT-1];
    assign o_m_axis_tdata  = OUT_W'({w_ang_out[2], w_ang_out[1], w_ang_out[0],
                                     w_side[2], w_side[1], w_side[0]});

    // A degenerate beat carries zero angles.
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |->
            o_m_axis_tdata[3*SIDE_W +: 3*ANGLE_W] == '0)
        else $error("degenerate beat with nonzero angle");

    // Angles never exceed a half turn when the field is wide enough to hold one.
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (ANGLE_FRAC_BITS <= 8) |->
            (32'(w_ang_out[0]) <= (32'd180 << ANGLE_FRAC_BITS))
            && (32'(w_ang_out[1]) <= (32'd180 << ANGLE_FRAC_BITS))
            && (32'(w_ang_out[2]) <= (32'd180 << ANGLE_FRAC_BITS)))
        else $error("angle beyond 180 degrees");

    // A proper triangle has no side of zero length.
    a_side_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] && (COORD_BITS <= 16) |->
            (w_side[0] != '0) && (w_side[1] != '0) && (w_side[2] != '0))
        else $error("zero side on a non-degenerate beat");

endmodule

// ===== hdl/tafv_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// Square root cell
// One digit of a restoring square root; a chain of these forms the root.
// ----------------------------------------------------------------------------
module tafv_sqrt_cell #(
    parameter int ROOT_BITS = 26
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [2*ROOT_BITS-1:0] i_rad,
    input  logic [ROOT_BITS+1:0]   i_rem,
    input  logic [ROOT_BITS-1:0]   i_root,
    output logic [2*ROOT_BITS-1:0] o_rad,
    output logic [ROOT_BITS+1:0]   o_rem,
    output logic [ROOT_BITS-1:0]   o_root
);

    logic [2*ROOT_BITS-1:0] r_rad, n_rad;
    logic [ROOT_BITS+1:0]   r_rem, n_rem;
    logic [ROOT_BITS-1:0]   r_root, n_root;
    logic [ROOT_BITS+1:0]   w_shift;
    logic [ROOT_BITS+1:0]   w_trial;

    always_comb begin
        w_shift = {i_rem[ROOT_BITS-1:0], i_rad[2*ROOT_BITS-1 -: 2]};
        w_trial = {i_root, 2'b01};
        n_rad   = i_rad << 2;
        if (w_shift >= w_trial) begin
            n_rem  = w_shift - w_trial;
            n_root = {i_root[ROOT_BITS-2:0], 1'b1};
        end else begin
            n_rem  = w_shift;
            n_root = {i_root[ROOT_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= n_rad;
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_rad  = r_rad;
    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

// ===== hdl/tafv_div_cell.sv =====
// ----------------------------------------------------------------------------
// Divider cell
// One quotient bit of a restoring division; the divisor travels along.
// ----------------------------------------------------------------------------
module tafv_div_cell #(
    parameter int DW = 52
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [DW-1:0]                     i_d,
    input  logic [DW-1:0]                     i_r,
    input  logic [tafv_pkg::DIV_STEPS-1:0]    i_q,
    output logic [DW-1:0]                     o_d,
    output logic [DW-1:0]                     o_r,
    output logic [tafv_pkg::DIV_STEPS-1:0]    o_q
);
    import tafv_pkg::*;

    logic [DW-1:0]        r_d, r_r, n_r;
    logic [DIV_STEPS-1:0] r_q, n_q;
    logic [DW:0]          w_r2;
    logic [DW:0]          w_diff;
    logic                 w_ge;

    always_comb begin
        w_r2   = {i_r, 1'b0};
        w_diff = w_r2 - {1'b0, i_d};
        w_ge   = (w_r2 >= {1'b0, i_d});
        n_r    = w_ge ? w_diff[DW-1:0] : w_r2[DW-1:0];
        n_q    = {i_q[DIV_STEPS-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= i_d;
            r_r <= n_r;
            r_q <= n_q;
        end
    end

    assign o_d = r_d;
    assign o_r = r_r;
    assign o_q = r_q;

endmodule

// ===== hdl/tafv_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// Rotation cell
// One vectoring step of the arccosine: drives y toward zero, sums the angle.
// ----------------------------------------------------------------------------
module tafv_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [tafv_pkg::XY_W-1:0]    i_x,
    input  logic signed [tafv_pkg::XY_W-1:0]    i_y,
    input  logic signed [tafv_pkg::Z_W-1:0]     i_z,
    output logic signed [tafv_pkg::XY_W-1:0]    o_x,
    output logic signed [tafv_pkg::XY_W-1:0]    o_y,
    output logic signed [tafv_pkg::Z_W-1:0]     o_z
);
    import tafv_pkg::*;

    logic signed [XY_W-1:0] r_x, r_y, n_x, n_y, w_xs, w_ys;
    logic signed [Z_W-1:0]  r_z, n_z, w_atan;

    always_comb begin
        w_xs   = shr_tz(i_x, STEP);
        w_ys   = shr_tz(i_y, STEP);
        w_atan = Z_W'(ATAN_DEG[STEP]);
        if (!i_y[XY_W-1]) begin
            n_x = i_x + w_ys;
            n_y = i_y - w_xs;
            n_z = i_z + w_atan;
        end else begin
            n_x = i_x - w_ys;
            n_y = i_y + w_xs;
            n_z = i_z - w_atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

// ===== hdl/tafv_angle_lane.sv =====
// ----------------------------------------------------------------------------
// Angle lane
// Cosine by division, sine by square root, angle by a chain of rotation cells.
// ----------------------------------------------------------------------------
module tafv_angle_lane #(
    parameter int LEN_W = 26,
    parameter int NUM_W = 34,
    parameter int ANGLE_FRAC_BITS = tafv_pkg::ANGLE_FRAC_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [NUM_W-1:0]              i_num_mag,
    input  logic                          i_num_neg,
    input  logic [LEN_W-1:0]              i_len_a,
    input  logic [LEN_W-1:0]              i_len_b,
    output logic [tafv_pkg::ANGLE_W-1:0]  o_angle
);
    import tafv_pkg::*;

    localparam int DPW = 2 * LEN_W;
    localparam int CMP_W = (NUM_W + DIV_PRE > DPW) ? NUM_W + DIV_PRE : DPW;
    localparam int RAD2_W = 2 * SQ2_STEPS;
    localparam logic [Z_W-1:0] RND = Z_W'(1 << (Z_FRAC - 1 - ANGLE_FRAC_BITS));

    // Stage 1: divisor product.
    logic [DPW-1:0]   r_d;
    logic [NUM_W-1:0] r_n;
    // Stage 2: scaled dividend and overflow check.
    logic [DPW-1:0]   r_d2, r_init;
    logic [CMP_W-1:0] w_nsh;
    logic             w_ovf;

    always_comb begin
        w_nsh = CMP_W'(r_n) << DIV_PRE;
        w_ovf = (w_nsh >= CMP_W'(r_d));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d    <= DPW'(i_len_a) * DPW'(i_len_b);
            r_n    <= i_num_mag;
            r_d2   <= r_d;
            r_init <= w_nsh[DPW-1:0];
        end
    end

    // Division chain.
    logic [DPW-1:0]       w_dd [DIV_STEPS+1];
    logic [DPW-1:0]       w_dr [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] w_dq [DIV_STEPS+1];

    assign w_dd[0] = r_d2;
    assign w_dr[0] = r_init;
    assign w_dq[0] = '0;

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        tafv_div_cell #(.DW(DPW)) u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_d   (w_dd[k]),
            .i_r   (w_dr[k]),
            .i_q   (w_dq[k]),
            .o_d   (w_dd[k+1]),
            .o_r   (w_dr[k+1]),
            .o_q   (w_dq[k+1])
        );
    end

    // Cap, round and clamp the cosine magnitude.
    logic                 r_ovf_dly [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] w_qc;
    logic [DIV_STEPS:0]   w_qr;
    logic [COS_W-1:0]     w_c;
    logic [COS_W-1:0]     r_c;
    logic [2*COS_W-1:0]   r_csq;
    logic [2*COS_W-1:0]   w_v;
    logic [RAD2_W-1:0]    r_rad;

    always_comb begin
        if (r_ovf_dly[DIV_STEPS] || (w_dq[DIV_STEPS] > QUOT_CAP)) begin
            w_qc = QUOT_CAP;
        end else begin
            w_qc = w_dq[DIV_STEPS];
        end
        w_qr = {1'b0, w_qc} + (DIV_STEPS + 1)'(1);
        if (w_qr[DIV_STEPS:1] > DIV_STEPS'(COS_ONE)) begin
            w_c = COS_ONE;
        end else begin
            w_c = COS_W'(w_qr[DIV_STEPS:1]);
        end
        w_v = ((2 * COS_W)'(1) << 32) - r_csq;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ovf_dly[0] <= w_ovf;
            for (int k = 1; k <= DIV_STEPS; k++) begin
                r_ovf_dly[k] <= r_ovf_dly[k-1];
            end
            r_c   <= w_c;
            r_csq <= (2 * COS_W)'(r_c) * (2 * COS_W)'(r_c);
            r_rad <= RAD2_W'({w_v[32:0], 2'b00});
        end
    end

    // Sine root chain.
    logic [RAD2_W-1:0]    w_srad  [SQ2_STEPS+1];
    logic [SQ2_STEPS+1:0] w_srem  [SQ2_STEPS+1];
    logic [SQ2_STEPS-1:0] w_sroot [SQ2_STEPS+1];

    assign w_srad[0]  = r_rad;
    assign w_srem[0]  = '0;
    assign w_sroot[0] = '0;

    for (genvar k = 0; k < SQ2_STEPS; k++) begin : g_sqrt
        tafv_sqrt_cell #(.ROOT_BITS(SQ2_STEPS)) u_cell (
            .i_clk  (i_clk),
            .i_en   (i_en),
            .i_rad  (w_srad[k]),
            .i_rem  (w_srem[k]),
            .i_root (w_sroot[k]),
            .o_rad  (w_srad[k+1]),
            .o_rem  (w_srem[k+1]),
            .o_root (w_sroot[k+1])
        );
    end

    // Cosine waits beside the root chain.
    logic [COS_W-1:0] r_c_dly [SQ2_STEPS+2];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_dly[0] <= r_c;
            for (int k = 1; k < SQ2_STEPS + 2; k++) begin
                r_c_dly[k] <= r_c_dly[k-1];
            end
        end
    end

    // Rotation chain on (cos, sin).
    logic [SQ2_STEPS:0]     w_sp;
    logic signed [XY_W-1:0] w_cx [CORDIC_STEPS+1];
    logic signed [XY_W-1:0] w_cy [CORDIC_STEPS+1];
    logic signed [Z_W-1:0]  w_cz [CORDIC_STEPS+1];

    always_comb begin
        w_sp    = {1'b0, w_sroot[SQ2_STEPS]} + (SQ2_STEPS + 1)'(1);
        w_cx[0] = XY_W'(r_c_dly[SQ2_STEPS+1]) << VEC_SHIFT;
        w_cy[0] = XY_W'(w_sp[SQ2_STEPS:1]) << VEC_SHIFT;
        w_cz[0] = '0;
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
        tafv_cordic_cell #(.STEP(k)) u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_x   (w_cx[k]),
            .i_y   (w_cy[k]),
            .i_z   (w_cz[k]),
            .o_x   (w_cx[k+1]),
            .o_y   (w_cy[k+1]),
            .o_z   (w_cz[k+1])
        );
    end

    // Sign of the cosine travels with the whole lane.
    logic                  r_neg_dly [LANE_LAT-1];
    logic signed [Z_W-1:0] w_zf;
    logic [Z_W-1:0]        w_zc;
    logic [Z_W-1:0]        w_zr;
    logic [Z_W-1:0]        w_ang;
    logic [ANGLE_W-1:0]    r_angle;

    always_comb begin
        w_zf = r_neg_dly[LANE_LAT-2] ? (HALF_TURN - w_cz[CORDIC_STEPS]) : w_cz[CORDIC_STEPS];
        if (w_zf < 0) begin
            w_zc = '0;
        end else if (w_zf > HALF_TURN) begin
            w_zc = HALF_TURN;
        end else begin
            w_zc = w_zf;
        end
        w_zr  = w_zc + RND;
        w_ang = w_zr >> (Z_FRAC - ANGLE_FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg_dly[0] <= i_num_neg;
            for (int k = 1; k < LANE_LAT - 1; k++) begin
                r_neg_dly[k] <= r_neg_dly[k-1];
            end
            r_angle <= ANGLE_W'(w_ang);
        end
    end

    assign o_angle = r_angle;

endmodule

// ===== test/triangle_angles_from_vertices_unit_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Triangle angle unit checker
// Watches both stream channels, computes the expected sides, angles and
// degenerate flag for every accepted triangle, and compares each output beat
// in order against the queue of pending results.
// ----------------------------------------------------------------------------
module triangle_angles_from_vertices_unit_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [95:0]                   i_in_data,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [tafv_pkg::OUT_W-1:0]    i_out_data,
    input  logic [0:0]                    i_out_user,
    output int                            o_errors,
    output int                            o_pending
);
    import tafv_pkg::*;

    typedef struct packed {
        logic             degenerate;
        logic [ANGLE_W-1:0] ang_c;
        logic [ANGLE_W-1:0] ang_b;
        logic [ANGLE_W-1:0] ang_a;
        logic [SIDE_W-1:0]  len_ab;
        logic [SIDE_W-1:0]  len_ac;
        logic [SIDE_W-1:0]  len_bc;
    } t_tri_result;

    t_tri_result triangle_results_q[$];
    int          errors = 0;

    assign o_errors  = errors;
    assign o_pending = triangle_results_q.size();

    localparam longint ATAN_TAB [CORDIC_STEPS] = '{
        47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658,
        469357, 234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29, 14, 7, 4, 2
    };

    // Digit-by-digit root with one extra bit, then round half up.
    function automatic longint unsigned root_rounded(input longint unsigned x,
                                                     input int frac);
        longint unsigned root, rem, trial;
        begin
            root = 0;
            rem = 0;
            for (int k = 0; k < 33 + frac; k++) begin
                rem = rem << 2;
                if (k < 32) rem = rem | ((x >> (62 - 2 * k)) & 3);
                trial = (root << 2) | 1;
                if (rem >= trial) begin
                    rem = rem - trial;
                    root = (root << 1) | 1;
                end else begin
                    root = root << 1;
                end
            end
            return (root + 1) >> 1;
        end
    endfunction

    function automatic longint unsigned cosine_magnitude(input longint unsigned n,
                                                         input longint unsigned la,
                                                         input longint unsigned lb);
        logic [127:0] quo;
        longint unsigned q;
        begin
            quo = ({64'd0, n} << 32) / ({64'd0, la} * {64'd0, lb});
            q = (quo > 128'd1048576) ? 64'd1048576 : quo[63:0];
            q = (q + 1) >> 1;
            return (q > 65536) ? 64'd65536 : q;
        end
    endfunction

    function automatic longint toward_zero_shift(input longint v, input int i);
        begin
            if (v >= 0) return v >>> i;
            return -((-v) >>> i);
        end
    endfunction

    function automatic logic [ANGLE_W-1:0] interior_angle(input longint num,
                                                          input longint unsigned la,
                                                          input longint unsigned lb);
        longint unsigned c, s;
        longint x, y, z, xs, ys;
        longint half_turn;
        begin
            half_turn = 180 * (64'sd1 << Z_FRAC);
            c = cosine_magnitude((num < 0) ? -num : num, la, lb);
            s = root_rounded((64'd1 << 32) - c * c, 0);
            x = c << VEC_SHIFT;
            y = s << VEC_SHIFT;
            z = 0;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                xs = toward_zero_shift(x, i);
                ys = toward_zero_shift(y, i);
                if (y >= 0) begin
                    x += ys; y -= xs; z += ATAN_TAB[i];
                end else begin
                    x -= ys; y += xs; z -= ATAN_TAB[i];
                end
            end
            if (num < 0) z = half_turn - z;
            if (z < 0) z = 0;
            if (z > half_turn) z = half_turn;
            return ANGLE_W'((z + (64'sd1 << (Z_FRAC - 1 - 8))) >>> (Z_FRAC - 8));
        end
    endfunction

    function automatic longint unsigned squared_distance(input longint x1, input longint y1,
                                                         input longint x2, input longint y2);
        begin
            return (x2 - x1) * (x2 - x1) + (y2 - y1) * (y2 - y1);
        end
    endfunction

    function automatic t_tri_result solve_triangle(input logic [95:0] d);
        longint ax, ay, bx, by, cx, cy;
        longint unsigned a2, b2, c2, la, lb, lc;
        t_tri_result r;
        begin
            ax = longint'($signed(d[15:0]));
            ay = longint'($signed(d[31:16]));
            bx = longint'($signed(d[47:32]));
            by = longint'($signed(d[63:48]));
            cx = longint'($signed(d[79:64]));
            cy = longint'($signed(d[95:80]));
            a2 = squared_distance(bx, by, cx, cy);
            b2 = squared_distance(ax, ay, cx, cy);
            c2 = squared_distance(ax, ay, bx, by);
            la = root_rounded(a2, LEN_FRAC);
            lb = root_rounded(b2, LEN_FRAC);
            lc = root_rounded(c2, LEN_FRAC);
            r = '0;
            r.len_bc = SIDE_W'(la);
            r.len_ac = SIDE_W'(lb);
            r.len_ab = SIDE_W'(lc);
            r.degenerate = (a2 == 0) || (b2 == 0) || (c2 == 0);
            if (!r.degenerate) begin
                r.ang_a = interior_angle(longint'(b2 + c2) - longint'(a2), lb, lc);
                r.ang_b = interior_angle(longint'(a2 + c2) - longint'(b2), la, lc);
                r.ang_c = interior_angle(longint'(a2 + b2) - longint'(c2), la, lb);
            end
            return r;
        end
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        begin
            $display("%0t: %s mismatch: got %0d expected %0d", $realtime, what, got, want);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_tri_result want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready)
                triangle_results_q.push_back(solve_triangle(i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (triangle_results_q.size() == 0) begin
                    // An output beat arrived with no triangle waiting for it.
                    report_mismatch("pending triangles", 0, 1);
                end else begin
                    want = triangle_results_q.pop_front();
                    if (i_out_data[24:0] !== want.len_bc)
                        report_mismatch("side_bc", i_out_data[24:0], want.len_bc);
                    if (i_out_data[49:25] !== want.len_ac)
                        report_mismatch("side_ac", i_out_data[49:25], want.len_ac);
                    if (i_out_data[74:50] !== want.len_ab)
                        report_mismatch("side_ab", i_out_data[74:50], want.len_ab);
                    if (i_out_data[90:75] !== want.ang_a)
                        report_mismatch("angle_at_a", i_out_data[90:75], want.ang_a);
                    if (i_out_data[106:91] !== want.ang_b)
                        report_mismatch("angle_at_b", i_out_data[106:91], want.ang_b);
                    if (i_out_data[122:107] !== want.ang_c)
                        report_mismatch("angle_at_c", i_out_data[122:107], want.ang_c);
                    if (i_out_user[0] !== want.degenerate)
                        report_mismatch("degenerate", i_out_user[0], want.degenerate);
                end
            end
        end
    end

endmodule

// ===== test/triangle_angles_from_vertices_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Triangle angle unit testbench
// Drives directed and random triangles under random source gaps and sink
// stalls, including one long sink hold-off; the checker judges each result.
// ----------------------------------------------------------------------------
module triangle_angles_from_vertices_unit_tb;
    import tafv_pkg::*;

    localparam int RANDOM_TRIANGLES = 800;
    localparam int DRAIN_CYCLES = 200;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [95:0]        s_tdata = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [OUT_W-1:0]   m_tdata;
    logic [0:0]         m_tuser;
    int                 errors;
    int                 pending;
    logic               sink_calm = 1'b0;
    logic               sink_hold = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    triangle_angles_from_vertices_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready), .i_s_axis_tdata(s_tdata),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata), .o_m_axis_tuser(m_tuser)
    );

    triangle_angles_from_vertices_unit_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_tvalid), .i_in_ready(s_tready), .i_in_data(s_tdata),
        .i_out_valid(m_tvalid), .i_out_ready(m_tready),
        .i_out_data(m_tdata), .i_out_user(m_tuser),
        .o_errors(errors), .o_pending(pending)
    );

    // Sink: random stalls, a calm stretch, and one long hold-off.
    always @(posedge i_clk) begin
        if (sink_hold)
            m_tready <= 1'b0;
        else if (sink_calm)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(99) >= 30);
    end

    initial begin
        repeat (600) @(posedge i_clk);
        sink_hold <= 1'b1;
        repeat (400) @(posedge i_clk);
        sink_hold <= 1'b0;
        repeat (300) @(posedge i_clk);
        sink_calm <= 1'b1;
        repeat (400) @(posedge i_clk);
        sink_calm <= 1'b0;
    end

    function automatic logic [15:0] rand_coord(input int mode);
        begin
            case (mode)
                0: return 16'h8000;
                1: return 16'h7FFF;
                2: return 16'($signed($urandom_range(40)) - 20);
                default: return 16'($urandom);
            endcase
        end
    endfunction

    // One beat; gaps drawn per beat, none during the calm stretch.
    task automatic send_triangle(input logic [95:0] vertices, input bit calm);
        begin
            while (!calm && $urandom_range(99) < 30) begin
                s_tvalid <= 1'b0;
                @(posedge i_clk);
            end
            s_tvalid <= 1'b1;
            s_tdata <= vertices;
            @(posedge i_clk);
            while (!s_tready) @(posedge i_clk);
        end
    endtask

    initial begin
        logic [95:0] v;
        int          mode;
        int          drain;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Extremes, coincident vertices, collinear points, right and obtuse angles.
        send_triangle({16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0);
        send_triangle({16'sd5, 16'sd5, 16'sd3, 16'sd1, 16'sd3, 16'sd1}, 1'b0);
        send_triangle({16'sd9, 16'sd2, 16'sd1, 16'sd1, 16'sd9, 16'sd2}, 1'b0);
        send_triangle({16'sd0, 16'sd3, 16'sd0, 16'sd0, 16'sd0, 16'sd4}, 1'b0);
        send_triangle({16'sd4, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd3}, 1'b0);
        send_triangle({16'sd3, 16'sd3, 16'sd2, 16'sd2, 16'sd1, 16'sd1}, 1'b0);
        send_triangle({16'sd0, 16'sd2, 16'sd0, 16'sd1, 16'sd0, 16'sd0}, 1'b0);
        send_triangle({16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000}, 1'b0);
        send_triangle({16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF}, 1'b0);
        send_triangle({16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 1'b0);
        send_triangle({16'sd1, 16'sd10000, 16'sd0, 16'sd0, 16'sd0, 16'h8000}, 1'b0);
        send_triangle({16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd1, 16'sd0}, 1'b0);
        send_triangle({16'sd1, 16'sd1, 16'h7FFF, 16'sd0, 16'sd0, 16'sd0}, 1'b0);
        send_triangle('1, 1'b0);
        send_triangle({48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000}, 1'b0);
        for (int n = 0; n < RANDOM_TRIANGLES; n++) begin
            mode = $urandom_range(9);
            for (int f = 0; f < 6; f++)
                v[16*f +: 16] = rand_coord((mode < 2) ? $urandom_range(3) :
                                           (mode < 4) ? 2 : 3);
            // Sometimes give B the x of A, force C onto B, or line all three vertices up.
            if (mode == 4) v[47:32] = v[15:0];
            if (mode == 5) v[95:64] = v[63:32];
            if (mode == 6) begin
                v[79:64] = v[15:0];
                v[47:32] = v[15:0];
            end
            send_triangle(v, sink_calm);
        end
        s_tvalid <= 1'b0;
        drain = 0;
        while (pending != 0 && drain < 20000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("triangle_angles_from_vertices_unit_tb: clean");
        else
            $display("triangle_angles_from_vertices_unit_tb: errors");
        $finish;
    end

    initial begin
        #200000;
        $display("triangle_angles_from_vertices_unit_tb: errors");
        $finish;
    end

endmodule
